>>> src/twqs_pkg.sv
// shared types, codes and constants of the two-queue weighted server
`timescale 1ns / 1ps

package twqs_pkg;

    // default queue depth and reset value of the preferred burst limit
    localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;
    localparam int unsigned BURST_W             = 4;
    localparam logic [BURST_W-1:0] BURST_RESET  = 4'd3;

    // configuration register map
    localparam int unsigned PADDR_W             = 3;
    localparam logic [0:0]  REG_PREFERRED_BURST = 1'b0;

    // input command codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_SERVE   = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_ENQUEUED = 3'd0,
        ST_FULL     = 3'd1,
        ST_SERVED_P = 3'd2,
        ST_SERVED_N = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // input item
    typedef struct packed {
        logic               cmd;
        logic signed [31:0] value;
        logic               to_normal;
    } in_item_t;

    // result item
    typedef struct packed {
        status_t            status;
        logic signed [31:0] served_value;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic load_read;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic need_read;
    } dp_stat_t;

endpackage

>>> src/twqs_ctrl.sv
// controller state machine: input acceptance, read sequencing, result valid
`timescale 1ns / 1ps

module twqs_ctrl
    import twqs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t dp_stat,
    output dp_cmd_t  dp_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    // take a new item while idle, once the result register is free or being emptied
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    assign dp_cmd.accept    = accept;
    assign dp_cmd.load_read = (state_reg == S_READ);

    // next state and result valid
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (dp_stat.need_read) begin
                        state_next   = S_READ;
                        m_valid_next = 1'b0;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end else if (m_valid_reg && m_ready) begin
                    m_valid_next = 1'b0;
                end
            end
            S_READ: begin
                state_next   = S_IDLE;
                m_valid_next = 1'b1;
            end
            default: begin
                state_next   = S_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> src/twqs_datapath.sv
// datapath: two ring-buffer queues, burst counter, limit register, result register
`timescale 1ns / 1ps

module twqs_datapath
    import twqs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  in_item_t           s_item,
    output out_item_t          m_item,
    input  dp_cmd_t            dp_cmd,
    output dp_stat_t           dp_stat,
    input  logic               cfg_we,
    input  logic [BURST_W-1:0] cfg_wdata,
    output logic [BURST_W-1:0] burst_limit
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    logic signed [31:0] pmem [QUEUE_DEPTH];
    logic signed [31:0] nmem [QUEUE_DEPTH];

    logic [PTR_W-1:0]   phead_reg, phead_next, nhead_reg, nhead_next;
    logic [CNT_W-1:0]   pcount_reg, pcount_next, ncount_reg, ncount_next;
    logic [BURST_W-1:0] burst_reg, burst_next;
    logic [BURST_W-1:0] limit_reg;
    logic signed [31:0] prd_reg, nrd_reg;
    logic               rd_normal_reg;
    out_item_t          out_reg;

    logic               p_nz, n_nz, serve_pref, need_read;
    logic               is_enq, enq_ok, enq_p, enq_n, pop;
    logic [SUM_W-1:0]   psum, nsum;
    logic [PTR_W-1:0]   ptail, ntail;

    // queue selection for a serve
    always_comb begin
        p_nz       = (pcount_reg != '0);
        n_nz       = (ncount_reg != '0);
        serve_pref = p_nz && (!n_nz || (burst_reg < limit_reg));
        need_read  = (s_item.cmd == CMD_SERVE) && (p_nz || n_nz);
    end

    assign dp_stat.need_read = need_read;
    assign burst_limit       = limit_reg;
    assign m_item            = out_reg;

    // tail positions of both rings
    always_comb begin
        psum  = SUM_W'(phead_reg) + SUM_W'(pcount_reg);
        nsum  = SUM_W'(nhead_reg) + SUM_W'(ncount_reg);
        ptail = (psum >= DEPTH_S) ? PTR_W'(psum - DEPTH_S) : PTR_W'(psum);
        ntail = (nsum >= DEPTH_S) ? PTR_W'(nsum - DEPTH_S) : PTR_W'(nsum);
    end

    // enqueue and pop decisions
    always_comb begin
        is_enq = dp_cmd.accept && (s_item.cmd == CMD_ENQUEUE);
        enq_ok = s_item.to_normal ? (ncount_reg != DEPTH_C) : (pcount_reg != DEPTH_C);
        enq_p  = is_enq && enq_ok && !s_item.to_normal;
        enq_n  = is_enq && enq_ok && s_item.to_normal;
        pop    = dp_cmd.accept && need_read;
    end

    // pointer, count and burst counter updates
    always_comb begin
        phead_next  = phead_reg;
        nhead_next  = nhead_reg;
        pcount_next = pcount_reg;
        ncount_next = ncount_reg;
        burst_next  = burst_reg;
        if (enq_p) begin
            pcount_next = pcount_reg + 1'b1;
        end
        if (enq_n) begin
            ncount_next = ncount_reg + 1'b1;
        end
        if (dp_cmd.accept && (s_item.cmd == CMD_SERVE)) begin
            if (!need_read) begin
                burst_next = '0;
            end else if (serve_pref) begin
                phead_next  = (phead_reg == LAST_P) ? '0 : phead_reg + 1'b1;
                pcount_next = pcount_reg - 1'b1;
                burst_next  = n_nz ? burst_reg + 1'b1 : '0;
            end else begin
                nhead_next  = (nhead_reg == LAST_P) ? '0 : nhead_reg + 1'b1;
                ncount_next = ncount_reg - 1'b1;
                burst_next  = '0;
            end
        end
    end

    // control state and limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phead_reg  <= '0;
            nhead_reg  <= '0;
            pcount_reg <= '0;
            ncount_reg <= '0;
            burst_reg  <= '0;
            limit_reg  <= BURST_RESET;
        end else begin
            phead_reg  <= phead_next;
            nhead_reg  <= nhead_next;
            pcount_reg <= pcount_next;
            ncount_reg <= ncount_next;
            burst_reg  <= burst_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // queue memories with registered read
    always_ff @(posedge aclk) begin
        if (enq_p) begin
            pmem[ptail] <= s_item.value;
        end
        if (enq_n) begin
            nmem[ntail] <= s_item.value;
        end
        if (pop) begin
            prd_reg       <= pmem[phead_reg];
            nrd_reg       <= nmem[nhead_reg];
            rd_normal_reg <= !serve_pref;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (dp_cmd.load_read) begin
            out_reg.status       <= rd_normal_reg ? ST_SERVED_N : ST_SERVED_P;
            out_reg.served_value <= rd_normal_reg ? nrd_reg : prd_reg;
        end else if (dp_cmd.accept && !need_read) begin
            if (s_item.cmd == CMD_ENQUEUE) begin
                out_reg.status <= enq_ok ? ST_ENQUEUED : ST_FULL;
            end else begin
                out_reg.status <= ST_EMPTY;
            end
            out_reg.served_value <= '0;
        end
    end

endmodule

>>> src/two_queue_weighted_server.sv
// Two-queue weighted server: top level with configuration port.
//
// Input channel s_valid/s_ready/s_item carries enqueue and serve commands;
// result channel m_valid/m_ready/m_item returns one status item per command.
// An enqueue, a refused enqueue and a serve with both queues empty give their
// result in the cycle after the transfer and can follow each other every cycle
// while the receiver keeps taking results.
// A serve that removes an entry goes through the registered queue memory read
// port first: the value is registered there and then in the result register,
// and no new command is taken while the read is in progress.
// The result register holds one item; while it waits for m_ready no new
// command is taken, and the pending result stays stable.
// Reset (aresetn low, synchronous) empties both queues, clears the burst
// counter and sets preferred_burst to 3; queue memory contents are not cleared.
// preferred_burst sits at byte address 0 of the APB port; the user must write
// it only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps

module two_queue_weighted_server
    import twqs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    dp_cmd_t            dp_cmd;
    dp_stat_t           dp_stat;
    logic               cfg_we;
    logic [BURST_W-1:0] burst_limit;
    logic [0:0]         reg_index;

    // register decode
    assign reg_index = paddr[2];
    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite && (reg_index == REG_PREFERRED_BURST);

    always_comb begin
        unique case (reg_index)
            REG_PREFERRED_BURST: prdata = {{(32 - BURST_W){1'b0}}, burst_limit};
            default:             prdata = '0;
        endcase
    end

    twqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd)
    );

    twqs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_item      (s_item),
        .m_item      (m_item),
        .dp_cmd      (dp_cmd),
        .dp_stat     (dp_stat),
        .cfg_we      (cfg_we),
        .cfg_wdata   (pwdata[BURST_W-1:0]),
        .burst_limit (burst_limit)
    );

endmodule

>>> src/twqs_checker.sv
// port-level checker for the two-queue weighted server, bound to the top level
`timescale 1ns / 1ps

module twqs_checker
    import twqs_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // no result is pending right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // non-serve statuses carry a zero value
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == ST_ENQUEUED || m_item.status == ST_FULL ||
                    m_item.status == ST_EMPTY) |-> m_item.served_value == '0)
        else $error("nonzero value on non-serve status");

    // an enqueue transfer gives its result in the next cycle
    a_enqueue_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_item.cmd == CMD_ENQUEUE) |=> m_valid &&
        (m_item.status == ST_ENQUEUED || m_item.status == ST_FULL))
        else $error("enqueue result missing");

endmodule

bind two_queue_weighted_server twqs_checker u_twqs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
